// ===== design/gmbtp_pkg.sv =====
// ----------------------------------------------------------------------------
// gmbtp_pkg
// Shared constants, types and helper functions for the gradient test pattern
// with a moving box.
// ----------------------------------------------------------------------------
package gmbtp_pkg;

  localparam int FRAME_W   = 32;  // frame number width
  localparam int COORD_W   = 12;  // pixel coordinate width
  localparam int DIM_W     = 13;  // frame dimension / divisor width
  localparam int DIM_EXT_W = 17;  // wide enough for any dimension limit
  localparam int CH_W      = 8;   // color channel width

  localparam int DEF_BOX_SIDE      = 36;
  localparam int DEF_MAX_DIMENSION = 4096;

  localparam int RESET_WIDTH  = 160;
  localparam int RESET_HEIGHT = 90;

  // configuration register indexes
  localparam int                CFG_IDX_W        = 2;
  localparam [CFG_IDX_W-1:0]    REG_FRAME_WIDTH  = 2'd0;
  localparam [CFG_IDX_W-1:0]    REG_FRAME_HEIGHT = 2'd1;

  // divider lanes
  localparam int LANES       = 4;
  localparam int LANE_MOD_X  = 0;  // box corner x: (5*f) mod span
  localparam int LANE_MOD_Y  = 1;  // box corner y: (3*f) mod span
  localparam int LANE_RAMP_X = 2;  // red ramp: 255*x / div
  localparam int LANE_RAMP_Y = 3;  // green ramp: 255*y / div

  localparam int STEPS_PER_STAGE = 4;
  localparam int DIV_STAGES      = FRAME_W / STEPS_PER_STAGE;

  localparam [CH_W-1:0] CH_FULL = 8'hff;
  localparam [CH_W-1:0] BOX_BLUE = 8'd32;

  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [CH_W-1:0]    blue;
  } side_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d, input int maxd);
    logic [DIM_W-1:0] res;
    res = d;
    if (d == '0) begin
      res = DIM_W'(1);
    end else if (DIM_EXT_W'(d) > DIM_EXT_W'(maxd)) begin
      res = DIM_W'(maxd);
    end
    return res;
  endfunction

  // ramp divisor: max(1, dim-1)
  function automatic logic [DIM_W-1:0] ramp_div(input logic [DIM_W-1:0] d);
    return (d > DIM_W'(1)) ? d - DIM_W'(1) : DIM_W'(1);
  endfunction

  // box range modulus: max(0, dim-side) + 1
  function automatic logic [DIM_W-1:0] span_div(input logic [DIM_W-1:0] d, input int side);
    logic [DIM_W:0] dx;
    logic [DIM_W:0] sx;
    logic [DIM_W-1:0] res;
    dx  = {1'b0, d};
    sx  = (DIM_W+1)'(side);
    res = DIM_W'(1);
    if (dx > sx) begin
      res = DIM_W'(dx - sx + (DIM_W+1)'(1));
    end
    return res;
  endfunction

endpackage

// ===== design/gmbtp_divpipe.sv =====
// ----------------------------------------------------------------------------
// gmbtp_divpipe
// Four-lane pipelined restoring divider, a fixed number of quotient bits per
// stage, with a valid bit and side data traveling alongside.
// ----------------------------------------------------------------------------
module gmbtp_divpipe
  import gmbtp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [FRAME_W-1:0] in_dividend [LANES],
  input  logic [DIM_W-1:0]   divisor     [LANES],
  input  side_t              in_side,
  output logic               out_valid,
  output logic [DIM_W-1:0]   out_rem     [LANES],
  output logic [CH_W-1:0]    out_quo     [LANES],
  output side_t              out_side
);

  logic               valid_r [DIV_STAGES];
  logic [FRAME_W-1:0] dvd_r   [DIV_STAGES][LANES];
  logic [DIM_W-1:0]   rem_r   [DIV_STAGES][LANES];
  logic [CH_W-1:0]    quo_r   [DIV_STAGES][LANES];
  side_t              side_r  [DIV_STAGES];

  for (genvar gs = 0; gs < DIV_STAGES; gs++) begin : g_stage
    logic               src_valid;
    logic [FRAME_W-1:0] src_dvd [LANES];
    logic [DIM_W-1:0]   src_rem [LANES];
    logic [CH_W-1:0]    src_quo [LANES];
    side_t              src_side;
    logic [FRAME_W-1:0] dvd_nxt [LANES];
    logic [DIM_W-1:0]   rem_nxt [LANES];
    logic [CH_W-1:0]    quo_nxt [LANES];

    if (gs == 0) begin : g_first
      assign src_valid = in_valid;
      assign src_side  = in_side;
      for (genvar gl = 0; gl < LANES; gl++) begin : g_lane
        assign src_dvd[gl] = in_dividend[gl];
        assign src_rem[gl] = '0;
        assign src_quo[gl] = '0;
      end
    end else begin : g_next
      assign src_valid = valid_r[gs-1];
      assign src_side  = side_r[gs-1];
      for (genvar gl = 0; gl < LANES; gl++) begin : g_lane
        assign src_dvd[gl] = dvd_r[gs-1][gl];
        assign src_rem[gl] = rem_r[gs-1][gl];
        assign src_quo[gl] = quo_r[gs-1][gl];
      end
    end

    always_comb begin
      logic [FRAME_W-1:0] d;
      logic [DIM_W-1:0]   r;
      logic [CH_W-1:0]    q;
      logic [DIM_W:0]     t;
      for (int l = 0; l < LANES; l++) begin
        d = src_dvd[l];
        r = src_rem[l];
        q = src_quo[l];
        for (int k = 0; k < STEPS_PER_STAGE; k++) begin
          t = {r, d[FRAME_W-1]};
          d = {d[FRAME_W-2:0], 1'b0};
          if (t >= {1'b0, divisor[l]}) begin
            r = DIM_W'(t - {1'b0, divisor[l]});
            q = {q[CH_W-2:0], 1'b1};
          end else begin
            r = t[DIM_W-1:0];
            q = {q[CH_W-2:0], 1'b0};
          end
        end
        dvd_nxt[l] = d;
        rem_nxt[l] = r;
        quo_nxt[l] = q;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[gs] <= 1'b0;
      end else begin
        valid_r[gs] <= src_valid;
      end
    end

    always_ff @(posedge clk) begin
      side_r[gs] <= src_side;
      for (int l = 0; l < LANES; l++) begin
        dvd_r[gs][l] <= dvd_nxt[l];
        rem_r[gs][l] <= rem_nxt[l];
        quo_r[gs][l] <= quo_nxt[l];
      end
    end
  end

  assign out_valid = valid_r[DIV_STAGES-1];
  assign out_side  = side_r[DIV_STAGES-1];
  assign out_rem   = rem_r[DIV_STAGES-1];
  assign out_quo   = quo_r[DIV_STAGES-1];

endmodule

// ===== design/gradient_moving_box_test_pattern.sv =====
// ----------------------------------------------------------------------------
// gradient_moving_box_test_pattern
// RGBA test pattern pixel generator: gradient ramps with a moving box.
// ----------------------------------------------------------------------------
// Pipeline: input register, 8 divider stages at 4 quotient bits each, then the
//   output register, from request to out_valid.
// Throughput: one request per cycle; busy stays low, the receiver cannot stall.
// Reset: synchronous active-low rst_n clears all valid bits and loads the
//   divisor registers from a 160 x 90 frame size.
module gradient_moving_box_test_pattern
  import gmbtp_pkg::*;
#(
  parameter int BOX_SIDE      = DEF_BOX_SIDE,
  parameter int MAX_DIMENSION = DEF_MAX_DIMENSION
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [FRAME_W-1:0]   in_frame_number,
  input  logic [COORD_W-1:0]   in_pixel_column,
  input  logic [COORD_W-1:0]   in_pixel_row,
  output logic                 out_valid,
  output logic [CH_W-1:0]      out_red,
  output logic [CH_W-1:0]      out_green,
  output logic [CH_W-1:0]      out_blue,
  output logic [CH_W-1:0]      out_alpha,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data
);

  localparam int PIPE_LAT = DIV_STAGES + 2;
  localparam logic [DIM_W-1:0] RST_W = clamp_dim(DIM_W'(RESET_WIDTH), MAX_DIMENSION);
  localparam logic [DIM_W-1:0] RST_H = clamp_dim(DIM_W'(RESET_HEIGHT), MAX_DIMENSION);

  // divisors derived from the frame size at write time
  logic [DIM_W-1:0] span_x_r, span_y_r, rdiv_x_r, rdiv_y_r;
  logic [DIM_W-1:0] cfg_dim;

  assign cfg_dim = clamp_dim(cfg_data, MAX_DIMENSION);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      span_x_r <= span_div(RST_W, BOX_SIDE);
      rdiv_x_r <= ramp_div(RST_W);
      span_y_r <= span_div(RST_H, BOX_SIDE);
      rdiv_y_r <= ramp_div(RST_H);
    end else if (cfg_we) begin
      if (cfg_index == REG_FRAME_WIDTH) begin
        span_x_r <= span_div(cfg_dim, BOX_SIDE);
        rdiv_x_r <= ramp_div(cfg_dim);
      end else if (cfg_index == REG_FRAME_HEIGHT) begin
        span_y_r <= span_div(cfg_dim, BOX_SIDE);
        rdiv_y_r <= ramp_div(cfg_dim);
      end
    end
  end

  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // input stage: scaled dividends
  logic               s0_valid_r;
  logic [FRAME_W-1:0] s0_dvd_r [LANES];
  side_t              s0_side_r;
  logic [FRAME_W-1:0] f3, f5;
  logic [19:0]        col255, row255;

  assign f3     = in_frame_number + {in_frame_number[FRAME_W-2:0], 1'b0};
  assign f5     = in_frame_number + {in_frame_number[FRAME_W-3:0], 2'b00};
  assign col255 = {in_pixel_column, 8'd0} - {8'd0, in_pixel_column};
  assign row255 = {in_pixel_row, 8'd0} - {8'd0, in_pixel_row};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else begin
      s0_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s0_dvd_r[LANE_MOD_X]  <= f5;
    s0_dvd_r[LANE_MOD_Y]  <= f3;
    s0_dvd_r[LANE_RAMP_X] <= FRAME_W'(col255);
    s0_dvd_r[LANE_RAMP_Y] <= FRAME_W'(row255);
    s0_side_r.col         <= in_pixel_column;
    s0_side_r.row         <= in_pixel_row;
    s0_side_r.blue        <= f3[CH_W-1:0];
  end

  logic [DIM_W-1:0] divisor [LANES];
  assign divisor[LANE_MOD_X]  = span_x_r;
  assign divisor[LANE_MOD_Y]  = span_y_r;
  assign divisor[LANE_RAMP_X] = rdiv_x_r;
  assign divisor[LANE_RAMP_Y] = rdiv_y_r;

  logic             dp_valid;
  logic [DIM_W-1:0] dp_rem [LANES];
  logic [CH_W-1:0]  dp_quo [LANES];
  side_t            dp_side;

  gmbtp_divpipe u_divpipe (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (s0_valid_r),
    .in_dividend (s0_dvd_r),
    .divisor     (divisor),
    .in_side     (s0_side_r),
    .out_valid   (dp_valid),
    .out_rem     (dp_rem),
    .out_quo     (dp_quo),
    .out_side    (dp_side)
  );

  // box test and color select
  logic [DIM_W:0] bx_end, by_end;
  logic           hit;

  assign bx_end = {1'b0, dp_rem[LANE_MOD_X]} + (DIM_W+1)'(BOX_SIDE);
  assign by_end = {1'b0, dp_rem[LANE_MOD_Y]} + (DIM_W+1)'(BOX_SIDE);
  assign hit = ({1'b0, dp_side.col} >= dp_rem[LANE_MOD_X]) &&
               ({2'b00, dp_side.col} < bx_end) &&
               ({1'b0, dp_side.row} >= dp_rem[LANE_MOD_Y]) &&
               ({2'b00, dp_side.row} < by_end);

  logic            out_valid_r;
  logic [CH_W-1:0] red_r, green_r, blue_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (hit) begin
      red_r   <= CH_FULL;
      green_r <= CH_FULL;
      blue_r  <= BOX_BLUE;
    end else begin
      red_r   <= dp_quo[LANE_RAMP_X];
      green_r <= dp_quo[LANE_RAMP_Y];
      blue_r  <= dp_side.blue;
    end
  end

  assign out_valid = out_valid_r;
  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;
  assign out_alpha = CH_FULL;

  // every request yields exactly one result on out_valid
  a_req_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##PIPE_LAT out_valid)
    else $error("request did not produce a result on time");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |-> ##PIPE_LAT !out_valid)
    else $error("result strobe without a matching request");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

  a_divisors_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (span_x_r != '0) && (span_y_r != '0) && (rdiv_x_r != '0) && (rdiv_y_r != '0))
    else $error("zero divisor loaded");

endmodule
